### src/lsw_pkg.sv
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types and constants of the link silence watchdog: the request and
// response payload structs, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lsw_pkg;

   // timestamp and register widths
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned CFG_WIDTH  = 31;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEAD_AFTER_MS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KICK_SPACING_MS = 2'd1;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] DEAD_AFTER_MS_RESET   = 31'd3000;
   localparam logic [CFG_WIDTH-1:0] KICK_SPACING_MS_RESET = 31'd10000;

   // event operations
   localparam logic OP_HEARD  = 1'b0;
   localparam logic OP_STRIKE = 1'b1;

   // zero time means no streak / never kicked
   localparam logic [TIME_WIDTH-1:0] TIME_NONE  = 32'd0;
   localparam logic [TIME_WIDTH-1:0] TIME_FIRST = 32'd1;

   typedef struct packed {
      logic                  operation;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic kick;
      logic dead;
   } rsp_type;

endpackage

`default_nettype wire

### src/link_silence_watchdog_top.sv
// ----------------------------------------------------------------------------
// link_silence_watchdog_top
// Tracks one-sided silence on a radio link and raises a re-join kick when a
// run of unanswered sends lasts too long, with a minimum kick spacing.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while the response side does not stall.
// An event is registered at the input, evaluated in the next cycle by a
// single compare/subtract stage against the streak registers, and its
// kick/dead result is held in an output register that drives the response
// port. The streak state is updated in the same cycle the event is
// evaluated, so back-to-back events always see the state left by the
// previous one. Registers are written through the csr port, which is
// always ready; write them only while no event is in flight.
`default_nettype none

module link_silence_watchdog_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire lsw_pkg::req_type                      req_data,
   // response channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      lsw_pkg::rsp_type                      rsp_data,
   // register write port
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [lsw_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [lsw_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import lsw_pkg::*;

   // registers
   logic [CFG_WIDTH-1:0]  dead_after_ff,   dead_after_in;
   logic [CFG_WIDTH-1:0]  kick_spacing_ff, kick_spacing_in;
   logic                  in_vld_ff,       in_vld_in;
   req_type               in_data_ff,      in_data_in;
   logic                  out_vld_ff,      out_vld_in;
   rsp_type               out_data_ff,     out_data_in;
   logic [TIME_WIDTH-1:0] start_ff,        start_in;
   logic [TIME_WIDTH-1:0] last_send_ff,    last_send_in;
   logic [TIME_WIDTH-1:0] last_kick_ff,    last_kick_in;

   // evaluation signals
   logic                  req_xfer;
   logic                  advance;
   logic                  csr_xfer;
   logic [TIME_WIDTH-1:0] stamp;
   logic [TIME_WIDTH-1:0] gap;
   logic [TIME_WIDTH-1:0] len;
   logic [TIME_WIDTH-1:0] kick_diff;
   logic [TIME_WIDTH-1:0] dead_after_ext;
   logic                  restart;
   logic                  reached;
   logic                  too_soon;
   logic                  kick;
   logic                  dead;

   // handshake control
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign in_data_in = req_xfer ? req_data : in_data_ff;
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   // register writes, upper bit dropped
   always_comb begin
      dead_after_in   = dead_after_ff;
      kick_spacing_in = kick_spacing_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_DEAD_AFTER_MS:   dead_after_in   = csr_wdata[CFG_WIDTH-1:0];
            CSR_KICK_SPACING_MS: kick_spacing_in = csr_wdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // strike arithmetic
   assign dead_after_ext = {1'b0, dead_after_ff};
   assign stamp     = (in_data_ff.now_ms != TIME_NONE) ? in_data_ff.now_ms : TIME_FIRST;
   assign gap       = stamp - last_send_ff;
   assign len       = stamp - start_ff;
   assign kick_diff = in_data_ff.now_ms - last_kick_ff;
   assign restart   = (start_ff == TIME_NONE) || (gap >= dead_after_ext);
   assign reached   = len >= dead_after_ext;
   assign too_soon  = (last_kick_ff != TIME_NONE) &&
                      (kick_diff[TIME_WIDTH-1] ||
                       (kick_diff[TIME_WIDTH-2:0] < kick_spacing_ff));

   // event evaluation and next streak state
   always_comb begin
      start_in     = start_ff;
      last_send_in = last_send_ff;
      last_kick_in = last_kick_ff;
      kick         = 1'b0;
      dead         = 1'b0;
      case (in_data_ff.operation)
         OP_HEARD: begin
            start_in     = TIME_NONE;
            last_send_in = TIME_NONE;
         end
         OP_STRIKE: begin
            if (restart) begin
               start_in     = stamp;
               last_send_in = stamp;
               dead         = (dead_after_ff == '0);
            end else if (reached && !too_soon) begin
               kick         = 1'b1;
               start_in     = TIME_NONE;
               last_send_in = TIME_NONE;
               last_kick_in = stamp;
            end else begin
               last_send_in = stamp;
               dead         = reached;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      out_data_in = out_data_ff;
      if (advance) begin
         out_data_in.kick = kick;
         out_data_in.dead = dead;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_after_ff   <= DEAD_AFTER_MS_RESET;
         kick_spacing_ff <= KICK_SPACING_MS_RESET;
         in_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
         start_ff        <= TIME_NONE;
         last_send_ff    <= TIME_NONE;
         last_kick_ff    <= TIME_NONE;
      end else begin
         dead_after_ff   <= dead_after_in;
         kick_spacing_ff <= kick_spacing_in;
         in_vld_ff       <= in_vld_in;
         out_vld_ff      <= out_vld_in;
         if (advance) begin
            start_ff     <= start_in;
            last_send_ff <= last_send_in;
            last_kick_ff <= last_kick_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
